/* rtl/dot_star_pattern_matcher_macros.svh */
// Assertion macros for the dot-star pattern matcher.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef DOT_STAR_PATTERN_MATCHER_MACROS_SVH
`define DOT_STAR_PATTERN_MATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define DSPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset
`define DSPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define DSPM_ASSERT_NOW(label, ante, cons)
`define DSPM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/dspm_pkg.sv */
// Shared types, constants and the row prefix function of the pattern matcher.
// No dependencies.
`default_nettype none

package dspm_pkg;

  localparam int MAX_TOKENS = 32;
  localparam int ROW_W      = MAX_TOKENS + 1;
  localparam int IDX_W      = $clog2(MAX_TOKENS);
  localparam int LEN_W      = $clog2(MAX_TOKENS + 1);
  localparam int LEVELS     = $clog2(ROW_W);

  // Fixed field widths of the request
  localparam int OP_W    = 2;
  localparam int TIDX_W  = 5;
  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 2;
  localparam int PLEN_W  = 6;

  // Token kind bits
  localparam int KIND_ANY_BIT  = 0;
  localparam int KIND_STAR_BIT = 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_CHAR   = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [MAX_TOKENS-1:0][CHAR_W-1:0] tok_chars_t;
  typedef logic [MAX_TOKENS-1:0][KIND_W-1:0] tok_kinds_t;

  // Token store write port
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] tchar;
    logic [KIND_W-1:0] kind;
  } tok_wr_t;

  // Row engine command
  typedef struct packed {
    logic              start;
    logic              text;
    logic [CHAR_W-1:0] text_char;
    logic [LEN_W-1:0]  length;
  } row_cmd_t;

  // Parallel prefix of new[j] = g[j] | (p[j] & new[j-1]), log-depth
  function automatic row_t prefix_chain(row_t g, row_t p);
    row_t gc;
    row_t pc;
    row_t gn;
    row_t pn;
    int   span;
    gc = g;
    pc = p;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      span = 1 << lvl;
      gn   = gc;
      pn   = pc;
      for (int j = 0; j < ROW_W; j++) begin
        if (j >= span) begin
          gn[j] = gc[j] | (pc[j] & gc[j-span]);
          pn[j] = pc[j] & pc[j-span];
        end
      end
      gc = gn;
      pc = pn;
    end
    return gc;
  endfunction

endpackage

`default_nettype wire

/* rtl/dspm_token_store.sv */
// Pattern token store: one character and one kind register per token.
// Depends on dspm_pkg.
`default_nettype none

module dspm_token_store (
  input  logic             clk_i,
  input  dspm_pkg::tok_wr_t wr_i,
  output dspm_pkg::tok_chars_t chars_o,
  output dspm_pkg::tok_kinds_t kinds_o
);
  import dspm_pkg::*;

  tok_chars_t chars_q;
  tok_kinds_t kinds_q;

  // Write one token per load request; contents undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      chars_q[wr_i.idx] <= wr_i.tchar;
      kinds_q[wr_i.idx] <= wr_i.kind;
    end
  end

  assign chars_o = chars_q;
  assign kinds_o = kinds_q;

endmodule

`default_nettype wire

/* rtl/dspm_row_engine.sv */
// Match row register and its registered update for start and text requests.
// Depends on dspm_pkg.
`default_nettype none

module dspm_row_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dspm_pkg::row_cmd_t   cmd_i,
  input  dspm_pkg::tok_chars_t chars_i,
  input  dspm_pkg::tok_kinds_t kinds_i,
  output logic                 matched_o
);
  import dspm_pkg::*;

  row_t             row_q, row_d;
  logic [LEN_W-1:0] len_q, len_d;

  row_t star;
  row_t hit;
  row_t char_gen;
  row_t start_gen;
  row_t len_mask;
  row_t char_row;
  row_t start_row;

  // Per-column token decode; column j holds token j-1
  always_comb begin
    star     = '0;
    hit      = '0;
    char_gen = '0;
    for (int j = 1; j < ROW_W; j++) begin
      star[j] = kinds_i[j-1][KIND_STAR_BIT];
      hit[j]  = kinds_i[j-1][KIND_ANY_BIT] | (cmd_i.text_char == chars_i[j-1]);
      if (star[j]) begin
        char_gen[j] = hit[j] & (row_q[j] | row_q[j-1]);
      end else begin
        char_gen[j] = hit[j] & row_q[j-1];
      end
    end
  end

  // Start row: empty text matches the run of leading star tokens
  always_comb begin
    start_gen    = '0;
    start_gen[0] = 1'b1;
    for (int j = 0; j < ROW_W; j++) begin
      len_mask[j] = (j <= int'(cmd_i.length));
    end
  end

  assign char_row  = prefix_chain(char_gen, star);
  assign start_row = prefix_chain(start_gen, star) & len_mask;

  // Select the next row and length
  always_comb begin
    row_d = row_q;
    len_d = len_q;
    if (cmd_i.start) begin
      row_d = start_row;
      len_d = cmd_i.length;
    end else if (cmd_i.text) begin
      row_d = char_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      len_q <= '0;
    end else begin
      row_q <= row_d;
      len_q <= len_d;
    end
  end

  assign matched_o = row_q[len_q];

endmodule

`default_nettype wire

/* rtl/dot_star_pattern_matcher.sv */
// Top level of the dot-star pattern matcher: input register, token store,
// row engine and result register. Depends on dspm_pkg and the macros header.
//
// Whole-string matcher for patterns of literal, any-character and starred
// tokens. Each request is registered, processed from that register and, for
// a finish request, its result lands in an output register. One request is
// taken every cycle: load, start and text requests never wait in the input
// register; a finish request retires as soon as the result register is free
// or being emptied, so only a held output with a finish waiting behind it
// stops the input. A result is valid the cycle after its finish request
// retires and, with the output ready, is taken at the following edge. No
// clearing pass after reset; the token store holds garbage until loaded.
`default_nettype none

module dot_star_pattern_matcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dspm_pkg::OP_W-1:0]   operation_i,
  input  logic [dspm_pkg::TIDX_W-1:0] token_index_i,
  input  logic [dspm_pkg::CHAR_W-1:0] token_char_i,
  input  logic [dspm_pkg::KIND_W-1:0] token_kind_i,
  input  logic [dspm_pkg::PLEN_W-1:0] pattern_length_i,
  input  logic [dspm_pkg::CHAR_W-1:0] text_char_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        matched_o
);
  import dspm_pkg::*;

  `include "dot_star_pattern_matcher_macros.svh"

  logic              s1_valid_q, s1_valid_d;
  op_e               s1_op_q;
  logic [TIDX_W-1:0] s1_idx_q;
  logic [CHAR_W-1:0] s1_tchar_q;
  logic [KIND_W-1:0] s1_kind_q;
  logic [PLEN_W-1:0] s1_plen_q;
  logic [CHAR_W-1:0] s1_text_q;

  logic out_valid_q, out_valid_d;
  logic out_matched_q;

  logic in_fire;
  logic s1_advance;
  logic fin_fire;
  logic engine_matched;

  tok_wr_t    tok_wr;
  row_cmd_t   row_cmd;
  tok_chars_t tok_chars;
  tok_kinds_t tok_kinds;

  // Handshake: a finish waits only while the result register is held
  assign s1_advance = s1_valid_q & ((s1_op_q != OP_FINISH) | !out_valid_q | out_ready_i);
  assign in_ready_o = !s1_valid_q | s1_advance;
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= op_e'(operation_i);
      s1_idx_q   <= token_index_i;
      s1_tchar_q <= token_char_i;
      s1_kind_q  <= token_kind_i;
      s1_plen_q  <= pattern_length_i;
      s1_text_q  <= text_char_i;
    end
  end

  // Decode the registered request into store writes and row commands
  always_comb begin
    tok_wr            = '0;
    row_cmd           = '0;
    fin_fire          = 1'b0;
    tok_wr.idx        = IDX_W'(s1_idx_q);
    tok_wr.tchar      = s1_tchar_q;
    tok_wr.kind       = s1_kind_q;
    row_cmd.text_char = s1_text_q;
    row_cmd.length    = (int'(s1_plen_q) > MAX_TOKENS) ? LEN_W'(MAX_TOKENS)
                                                       : LEN_W'(s1_plen_q);
    unique case (s1_op_q)
      OP_LOAD:   tok_wr.en     = s1_advance & (int'(s1_idx_q) < MAX_TOKENS);
      OP_START:  row_cmd.start = s1_advance;
      OP_CHAR:   row_cmd.text  = s1_advance;
      OP_FINISH: fin_fire      = s1_advance;
      default:   fin_fire      = 1'b0;
    endcase
  end

  dspm_token_store u_store (
    .clk_i   (clk_i),
    .wr_i    (tok_wr),
    .chars_o (tok_chars),
    .kinds_o (tok_kinds)
  );

  dspm_row_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (row_cmd),
    .chars_i   (tok_chars),
    .kinds_i   (tok_kinds),
    .matched_o (engine_matched)
  );

  // Result register: load on finish, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_matched_q <= engine_matched;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = out_matched_q;

  // A retired finish always shows up as a result
  `DSPM_ASSERT_NEXT(a_finish_gives_result, fin_fire, out_valid_o)
  // The input register stalls only behind a held result
  `DSPM_ASSERT_NOW(a_stall_only_on_held_output, s1_valid_q && !s1_advance,
                   out_valid_q && !out_ready_i && (s1_op_q == OP_FINISH))
  // An accepted request is always present in the input register next cycle
  `DSPM_ASSERT_NEXT(a_accept_fills_stage, in_fire, s1_valid_q)
  // Start and text commands never fire together
  `DSPM_ASSERT_NOW(a_row_cmd_exclusive, row_cmd.start, !row_cmd.text && !fin_fire)

endmodule

`default_nettype wire
